>>> hw/rtl/lzwe_pkg.sv
// Shared types and constants for the LZW byte encoder.
// No dependencies; used by lzw_byte_encoder.sv.

package lzwe_pkg;

  // Fixed field widths of the stream interface.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 13;

  // Codes below this value are raw bytes; dictionary strings follow it.
  localparam int unsigned RAW_CODES = 256;

  // Stream generation tag kept in each dictionary slot.
  localparam int unsigned EPOCH_W = 4;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CMP,
    ST_EMIT,
    ST_FLUSH
  } lzwe_state_e;

endpackage

>>> hw/rtl/lzwe_hash.sv
// Hash slot unit: reduces a (prefix * 31 + byte) value modulo the slot count.
// Standalone; instantiated by lzw_byte_encoder.sv.

module lzwe_hash #(
  parameter int unsigned VAL_W = 15,
  parameter int unsigned SLOTS = 8192
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [VAL_W-1:0]           val_i,
  output logic                       done_o,
  output logic [$clog2(SLOTS)-1:0]   slot_o
);

  localparam int unsigned HW      = $clog2(SLOTS);
  localparam bit          POW2    = ((SLOTS & (SLOTS - 1)) == 0);
  localparam int unsigned SHIFT   = VAL_W + HW;
  localparam int unsigned RECIP_W = VAL_W + 1;
  localparam int unsigned PROD_W  = VAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << SHIFT) / 64'(SLOTS));
  localparam logic [HW:0] SLOTS_R = (HW + 1)'(SLOTS);

  logic [2:0]         stg_q;
  logic [VAL_W-1:0]   val_q;
  logic [VAL_W-1:0]   val2_q;
  logic [PROD_W-1:0]  prod_q;
  logic [HW:0]        rem_q;
  logic [VAL_W-1:0]   quot;
  logic [VAL_W-1:0]   quot_slots;
  logic [HW:0]        rem_fix;

  // The quotient estimate is exact or one short, so the remainder lies
  // below twice the slot count and one conditional subtract settles it.
  assign quot       = VAL_W'(prod_q >> SHIFT);
  assign quot_slots = VAL_W'(quot * VAL_W'(SLOTS));
  assign rem_fix    = (rem_q >= SLOTS_R) ? (rem_q - SLOTS_R) : rem_q;

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= {stg_q[1:0], start_i && !POW2};
    end
  end

  // Reciprocal multiply, remainder, correction.
  always_ff @(posedge clk_i) begin
    val_q  <= val_i;
    prod_q <= PROD_W'(val_q) * PROD_W'(RECIP);
    val2_q <= val_q;
    rem_q  <= (HW + 1)'(val2_q - quot_slots);
  end

  // A power-of-two slot count needs only the low bits.
  assign done_o = POW2 ? start_i : stg_q[2];
  assign slot_o = POW2 ? HW'(val_i) : HW'(rem_fix);

endmodule

>>> hw/rtl/lzw_byte_encoder.sv
// LZW byte encoder top level: sequencer, hash dictionary memory, result register.
// Depends on lzwe_pkg and lzwe_hash.

// The encoder takes one byte per request and emits 13-bit codes: 0-255 for a
// raw byte, 256 plus the dictionary index for a longer string; the code that
// closes a stream carries out_last_o. The dictionary is a single memory of
// HASH_SLOTS slots with a registered read, probed linearly from (prefix *
// 31 + byte) mod HASH_SLOTS. The first byte of a stream just becomes the
// prefix. Any other byte is hashed and then probed, passing over each
// occupied slot, and a byte that ends the current string produces a code;
// a last byte adds a flush code. Each cycle that loads a code is held back
// while the output register still holds a code that has not been taken.
// When HASH_SLOTS is not a power of two the modulo unit adds its registered
// stages to each lookup. Each slot carries a stream tag so that ending a
// stream empties the dictionary at once; after reset, and after every
// sixteenth stream, a clearing pass over all HASH_SLOTS slots runs during
// which no byte is accepted. Results wait in an output register, so a new
// byte is accepted while the previous code is still waiting to be taken.

module lzw_byte_encoder #(
  parameter int unsigned DICT_ENTRIES = 4096,
  parameter int unsigned HASH_SLOTS   = 8192
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lzwe_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                        in_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lzwe_pkg::CODE_W-1:0] out_code_o,
  output logic                        out_last_o
);

  localparam int unsigned BW     = lzwe_pkg::BYTE_W;
  localparam int unsigned EW     = lzwe_pkg::EPOCH_W;
  localparam int unsigned IDX_W  = $clog2(DICT_ENTRIES);
  localparam int unsigned NIDX_W = $clog2(DICT_ENTRIES + 1);
  localparam int unsigned PFX_W  = $clog2(DICT_ENTRIES + lzwe_pkg::RAW_CODES);
  localparam int unsigned VAL_W  = PFX_W + 6;
  localparam int unsigned HW     = $clog2(HASH_SLOTS);
  localparam int unsigned SLOT_W = 1 + EW + PFX_W + BW + IDX_W;

  localparam logic [HW-1:0]     SLOT_LAST = HW'(HASH_SLOTS - 1);
  localparam logic [NIDX_W-1:0] DICT_LIM  = NIDX_W'(DICT_ENTRIES);
  localparam logic [PFX_W-1:0]  RAW_BASE  = PFX_W'(lzwe_pkg::RAW_CODES);
  localparam logic [EW-1:0]     EPOCH_MAX = '1;

  lzwe_pkg::lzwe_state_e state_q, state_d;

  logic                present_q;
  logic [PFX_W-1:0]    prefix_q;
  logic [BW-1:0]       byte_q;
  logic                last_q;
  logic [NIDX_W-1:0]   next_index_q;
  logic [EW-1:0]       epoch_q;
  logic [HW-1:0]       clr_q;
  logic [HW-1:0]       addr_q;
  logic [HW-1:0]       probe_q;
  logic                out_valid_q;
  logic [lzwe_pkg::CODE_W-1:0] out_code_q;
  logic                out_last_q;

  // Dictionary memory and its ports.
  logic [SLOT_W-1:0]   dict_mem [HASH_SLOTS];
  logic [SLOT_W-1:0]   rd_data_q;
  logic                rd_en;
  logic [HW-1:0]       rd_addr;
  logic                wr_en;
  logic [HW-1:0]       wr_addr;
  logic [SLOT_W-1:0]   wr_data;

  logic                accept;
  logic                out_free;
  logic                out_load;
  logic [lzwe_pkg::CODE_W-1:0] out_code_d;
  logic                out_last_d;
  logic [VAL_W-1:0]    hash_val;
  logic                hash_start;
  logic                hash_done;
  logic [HW-1:0]       hash_slot;
  logic [HW-1:0]       addr_next;

  logic                slot_valid;
  logic [EW-1:0]       slot_epoch;
  logic [PFX_W-1:0]    slot_pfx;
  logic [BW-1:0]       slot_byte;
  logic [IDX_W-1:0]    slot_idx;
  logic                slot_live;
  logic                slot_match;
  logic                probe_last;
  logic                probe_more;
  logic                add_ok;
  logic                clr_done;

  // Handshake terms.
  assign in_ready_o = (state_q == lzwe_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Hash input: prefix * 31 + byte.
  assign hash_val   = VAL_W'({prefix_q, 5'b0}) - VAL_W'(prefix_q) + VAL_W'(in_byte_i);
  assign hash_start = accept && present_q;

  lzwe_hash #(
    .VAL_W (VAL_W),
    .SLOTS (HASH_SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .val_i   (hash_val),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  // Slot decode; a slot from an earlier stream counts as empty.
  assign slot_valid = rd_data_q[SLOT_W-1];
  assign slot_epoch = rd_data_q[SLOT_W-2 -: EW];
  assign slot_pfx   = rd_data_q[IDX_W+BW +: PFX_W];
  assign slot_byte  = rd_data_q[IDX_W +: BW];
  assign slot_idx   = rd_data_q[IDX_W-1:0];
  assign slot_live  = slot_valid && (slot_epoch == epoch_q);
  assign slot_match = slot_live && (slot_pfx == prefix_q) && (slot_byte == byte_q);
  assign probe_last = (probe_q == SLOT_LAST);
  assign probe_more = slot_live && !slot_match && !probe_last;
  assign add_ok     = !slot_live && (next_index_q < DICT_LIM);
  assign addr_next  = (addr_q == SLOT_LAST) ? '0 : addr_q + 1'b1;
  assign clr_done   = (clr_q == SLOT_LAST);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzwe_pkg::ST_CLEAR: begin
        if (clr_done) state_d = lzwe_pkg::ST_IDLE;
      end
      lzwe_pkg::ST_IDLE: begin
        if (accept) begin
          if (!present_q) begin
            state_d = in_last_i ? lzwe_pkg::ST_FLUSH : lzwe_pkg::ST_IDLE;
          end else begin
            state_d = hash_done ? lzwe_pkg::ST_CMP : lzwe_pkg::ST_HASH;
          end
        end
      end
      lzwe_pkg::ST_HASH: begin
        if (hash_done) state_d = lzwe_pkg::ST_CMP;
      end
      lzwe_pkg::ST_CMP: begin
        if (slot_match) begin
          state_d = last_q ? lzwe_pkg::ST_FLUSH : lzwe_pkg::ST_IDLE;
        end else if (!probe_more) begin
          state_d = lzwe_pkg::ST_EMIT;
        end
      end
      lzwe_pkg::ST_EMIT: begin
        if (out_free) state_d = last_q ? lzwe_pkg::ST_FLUSH : lzwe_pkg::ST_IDLE;
      end
      lzwe_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_d = (epoch_q == EPOCH_MAX) ? lzwe_pkg::ST_CLEAR : lzwe_pkg::ST_IDLE;
        end
      end
      default: state_d = lzwe_pkg::ST_CLEAR;
    endcase
  end

  // Memory port control and result loading. Reads start only on a new byte
  // or during probing, writes only in the compare state or the clearing
  // pass, so a read and a write never meet on the same entry.
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = hash_slot;
    wr_en      = 1'b0;
    wr_addr    = addr_q;
    wr_data    = {1'b1, epoch_q, prefix_q, byte_q, IDX_W'(next_index_q)};
    out_load   = 1'b0;
    out_code_d = lzwe_pkg::CODE_W'(prefix_q);
    out_last_d = 1'b0;
    unique case (state_q)
      lzwe_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      lzwe_pkg::ST_IDLE: begin
        rd_en = hash_start && hash_done;
      end
      lzwe_pkg::ST_HASH: begin
        rd_en = hash_done;
      end
      lzwe_pkg::ST_CMP: begin
        rd_en   = probe_more;
        rd_addr = addr_next;
        wr_en   = !slot_match && !probe_more && add_ok;
      end
      lzwe_pkg::ST_EMIT: begin
        out_load = out_free;
      end
      lzwe_pkg::ST_FLUSH: begin
        out_load   = out_free;
        out_last_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Dictionary memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) dict_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= dict_mem[rd_addr];
  end

  // Sequencer and encoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lzwe_pkg::ST_CLEAR;
      present_q    <= 1'b0;
      prefix_q     <= '0;
      byte_q       <= '0;
      last_q       <= 1'b0;
      next_index_q <= '0;
      epoch_q      <= '0;
      clr_q        <= '0;
      addr_q       <= '0;
      probe_q      <= '0;
    end else begin
      state_q <= state_d;

      if (state_q == lzwe_pkg::ST_CLEAR) begin
        clr_q <= clr_done ? '0 : clr_q + 1'b1;
      end

      // New byte; the first byte of a stream just becomes the prefix.
      if (accept) begin
        byte_q <= in_byte_i;
        last_q <= in_last_i;
        if (!present_q) begin
          prefix_q  <= PFX_W'(in_byte_i);
          present_q <= 1'b1;
        end
      end

      if (rd_en) begin
        addr_q  <= rd_addr;
        probe_q <= (state_q == lzwe_pkg::ST_CMP) ? probe_q + 1'b1 : '0;
      end

      // Known string grows the prefix.
      if (state_q == lzwe_pkg::ST_CMP && slot_match) begin
        prefix_q <= RAW_BASE + PFX_W'(slot_idx);
      end

      if (wr_en && state_q == lzwe_pkg::ST_CMP) begin
        next_index_q <= next_index_q + 1'b1;
      end

      // After the prefix code leaves, the prefix restarts at the byte.
      if (state_q == lzwe_pkg::ST_EMIT && out_free) begin
        prefix_q <= PFX_W'(byte_q);
      end

      // End of stream empties everything; the new tag retires all slots.
      if (state_q == lzwe_pkg::ST_FLUSH && out_free) begin
        present_q    <= 1'b0;
        prefix_q     <= '0;
        next_index_q <= '0;
        epoch_q      <= epoch_q + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_code_q  <= '0;
      out_last_q  <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_code_q  <= out_code_d;
      out_last_q  <= out_last_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

  // The single-port discipline keeps reads and writes in separate cycles.
  a_no_rd_wr_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("dictionary read and write in the same cycle");

  // The entry count never passes the dictionary size.
  a_index_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_index_q <= DICT_LIM)
    else $error("next index beyond dictionary size");

  // A flush code leaves the encoder without a prefix.
  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (!present_q && next_index_q == '0))
    else $error("stream state not cleared after flush");

  // Probing stops after the last slot has been examined.
  a_probe_stop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzwe_pkg::ST_CMP && probe_last) |-> !rd_en)
    else $error("probe beyond table size");

  // A hash result only arrives for a byte that is being looked up.
  a_hash_owned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (hash_start || state_q == lzwe_pkg::ST_HASH))
    else $error("unexpected hash result");

endmodule
